// ===== sv/ppq_pkg.sv =====
// package: constants, codes and request/response types for the process queue
`timescale 1ns / 1ps
package ppq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int NUMBER_BITS   = 16;
	localparam int PRIORITY_BITS = 4;
	localparam int STATUS_BITS   = 2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_SERVE  = 1'b1;

	localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic                     func;
		logic [PRIORITY_BITS-1:0] new_priority;
	} req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0]   status;
		logic [NUMBER_BITS-1:0]   process_number;
		logic [PRIORITY_BITS-1:0] served_priority;
	} rsp_t;

	typedef struct packed {
		logic [NUMBER_BITS-1:0]   number;
		logic [PRIORITY_BITS-1:0] priority_lvl;
	} entry_t;

endpackage

// ===== sv/ppq_store.sv =====
// entry memory: one write port, one registered read port
`timescale 1ns / 1ps
module ppq_store #(
	parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH,
	localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  ppq_pkg::entry_t    wr_data,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	output ppq_pkg::entry_t    rd_data
);

	ppq_pkg::entry_t mem_q [QUEUE_DEPTH];
	ppq_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/ppq_scan.sv =====
// compare unit: keeps the earliest entry of strictly highest priority
`timescale 1ns / 1ps
module ppq_scan #(
	parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH,
	localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
	input  logic               clk,
	input  logic               vld,
	input  logic [IDX_W-1:0]   idx,
	input  ppq_pkg::entry_t    cand,
	output ppq_pkg::entry_t    best,
	output logic [IDX_W-1:0]   best_idx
);

	ppq_pkg::entry_t  best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             take;

	// head entry always taken, later ones only when strictly higher
	assign take = vld && ((idx == '0) || (cand.priority_lvl > best_q.priority_lvl));

	always_ff @(posedge clk) begin
		if (take) begin
			best_q     <= cand;
			best_idx_q <= idx;
		end
	end

	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule

// ===== sv/priority_process_queue_unit.sv =====
// top level: sequencer, counters and response register of the process queue
// insert, or any request that ends in an empty or full status: on acceptance the sequencer
// goes to the result state, then loads the response register once that register is free.
// serve: one memory read per cycle for the priority scan, then one per cycle to close up.
// one request at a time; the next is taken once the sequencer is back to idle.
// reset: asynchronous, active low; queue empty, next number 1, memory left as is.
`timescale 1ns / 1ps
module priority_process_queue_unit #(
	parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ppq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ppq_pkg::rsp_t rsp
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_SHIFT  = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	logic [1:0]                      state_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [ppq_pkg::NUMBER_BITS-1:0] num_q;
	logic [CNT_W-1:0]                rd_q;
	logic                            vld_s1;
	logic [IDX_W-1:0]                idx_s1;
	ppq_pkg::rsp_t                   res_q;
	ppq_pkg::rsp_t                   rsp_q;
	logic                            rsp_valid_q;

	logic             accept;
	logic             do_insert;
	logic             rd_issue;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	ppq_pkg::entry_t  wr_data;
	ppq_pkg::entry_t  rd_data;
	ppq_pkg::entry_t  best;
	logic [IDX_W-1:0] best_idx;
	logic             pass_done;
	logic             rsp_load;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign do_insert = accept && (req.func == ppq_pkg::FUNC_INSERT) && (cnt_q != DEPTH_C);

	assign rd_issue  = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (rd_q < cnt_q);
	assign rd_addr   = rd_q[IDX_W-1:0];
	assign pass_done = (rd_q == cnt_q) && !vld_s1;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[IDX_W-1:0];
		wr_data = '{number: num_q, priority_lvl: req.new_priority};
		if (do_insert) begin
			wr_en = 1'b1;
		end else if ((state_q == ST_SHIFT) && vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 - IDX_W'(1);
			wr_data = rd_data;
		end
	end

	ppq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_issue),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ppq_scan #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_scan (
		.clk      (clk),
		.vld      ((state_q == ST_SCAN) && vld_s1),
		.idx      (idx_s1),
		.cand     (rd_data),
		.best     (best),
		.best_idx (best_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			idx_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			num_q   <= ppq_pkg::NUMBER_BITS'(1);
			rd_q    <= '0;
		end else begin
			if (rd_issue) begin
				rd_q <= rd_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.func == ppq_pkg::FUNC_INSERT) begin
							state_q <= ST_RESULT;
							if (cnt_q != DEPTH_C) begin
								cnt_q <= cnt_q + CNT_W'(1);
								num_q <= num_q + ppq_pkg::NUMBER_BITS'(1);
							end
						end else if (cnt_q == '0) begin
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_SCAN;
							rd_q    <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (pass_done) begin
						state_q <= ST_SHIFT;
						rd_q    <= CNT_W'(best_idx) + CNT_W'(1);
					end
				end
				ST_SHIFT: begin
					if (pass_done) begin
						state_q <= ST_RESULT;
						cnt_q   <= cnt_q - CNT_W'(1);
					end
				end
				ST_RESULT: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.func == ppq_pkg::FUNC_INSERT) begin
				if (cnt_q != DEPTH_C) begin
					res_q <= '{status: ppq_pkg::STATUS_DONE, process_number: num_q,
						served_priority: '0};
				end else begin
					res_q <= '{status: ppq_pkg::STATUS_FULL, process_number: '0,
						served_priority: '0};
				end
			end else begin
				res_q <= '{status: ppq_pkg::STATUS_EMPTY, process_number: '0,
					served_priority: '0};
			end
		end else if ((state_q == ST_SHIFT) && pass_done) begin
			res_q <= '{status: ppq_pkg::STATUS_DONE, process_number: best.number,
				served_priority: best.priority_lvl};
		end
	end

	// response register frees the sequencer from the far side
	assign rsp_load = (state_q == ST_RESULT) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("entry count beyond queue depth");

	a_num_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(num_q) |-> $past(do_insert))
		else $error("process number moved without an insert");

	a_empty_serve: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.func == ppq_pkg::FUNC_SERVE) && (cnt_q == '0)) |=>
		((state_q == ST_RESULT) && (res_q.status == ppq_pkg::STATUS_EMPTY)))
		else $error("serve on empty queue did not report empty");

	a_shift_index: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SHIFT) && vld_s1) |-> (idx_s1 != '0))
		else $error("close-up write below the head");

endmodule
